>>> src/idt_pkg.sv
`timescale 1ns / 1ps

package idt_pkg;

	localparam int MAX_ENTRIES_DEF = 16;

	localparam int KEY_W  = 16;
	localparam int HID_W  = 8;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 4;
	localparam int CNT_W  = 5;

	localparam logic [REQ_W-1:0] REQ_STORE  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] ST_ABSENT = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

	// Update command broadcast to every cell in the commit cycle
	typedef struct packed {
		logic replace;
		logic append;
		logic clear;
	} op_t;

endpackage

>>> src/idt_cell.sv
`timescale 1ns / 1ps

module idt_cell #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic                     clk,
	input  logic [idt_pkg::KEY_W-1:0] probe_key,
	input  logic [idt_pkg::HID_W-1:0] probe_hid,
	input  logic [CNT_W-1:0]          count,
	input  idt_pkg::op_t              op,
	input  logic                      prev_hit,
	input  logic [idt_pkg::KEY_W-1:0] nb_key,
	input  logic [idt_pkg::HID_W-1:0] nb_hid,
	output logic [idt_pkg::KEY_W-1:0] key,
	output logic [idt_pkg::HID_W-1:0] hid,
	output logic                      first,
	output logic                      hit_out
);

	logic [idt_pkg::KEY_W-1:0] key_q;
	logic [idt_pkg::HID_W-1:0] hid_q;
	logic                      live;
	logic                      match;
	logic                      at_tail;

	assign live    = CNT_W'(IDX) < count;
	assign at_tail = CNT_W'(IDX) == count;
	assign match   = live && (key_q == probe_key);
	assign first   = match && !prev_hit;
	assign hit_out = prev_hit || match;
	assign key     = key_q;
	assign hid     = hid_q;

	always_ff @(posedge clk) begin
		if (op.replace && first) begin
			hid_q <= probe_hid;
		end else if (op.append && at_tail) begin
			key_q <= probe_key;
			hid_q <= probe_hid;
		end else if (op.clear && hit_out && live) begin
			// shift the upper neighbor down over the removed entry
			key_q <= nb_key;
			hid_q <= nb_hid;
		end
	end

endmodule

>>> src/interrupt_dispatch_table.sv
`timescale 1ns / 1ps
// The request is captured into the request register at the input transfer, then
// matched across the cell row and committed into the output result register.
// A new request is taken only after the captured one commits;
// a result held by out_ready low holds off the commit and keeps in_ready low.
// Reset: arst_n clears the entry count and the handshake state; table contents
// are left unknown and are never read above the count.

module interrupt_dispatch_table #(
	parameter int MAX_ENTRIES = idt_pkg::MAX_ENTRIES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [idt_pkg::REQ_W-1:0]    req_type,
	input  logic [idt_pkg::KEY_W-1:0]    source_key,
	input  logic [idt_pkg::HID_W-1:0]    handler_id,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic [idt_pkg::SLOT_W-1:0]   slot,
	output logic [idt_pkg::HID_W-1:0]    found_handler,
	output logic [idt_pkg::CNT_W-1:0]    entry_count,
	output logic [idt_pkg::STAT_W-1:0]   status
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int IW = $clog2(MAX_ENTRIES);

	// Captured request
	logic [idt_pkg::REQ_W-1:0] req_s1;
	logic [idt_pkg::KEY_W-1:0] key_s1;
	logic [idt_pkg::HID_W-1:0] hid_s1;
	logic                      busy_q;

	logic [CW-1:0] count_q;

	// Result register
	logic                        out_valid_q;
	logic                        hit_q;
	logic [idt_pkg::SLOT_W-1:0]  slot_q;
	logic [idt_pkg::HID_W-1:0]   found_q;
	logic [idt_pkg::CNT_W-1:0]   cnt_out_q;
	logic [idt_pkg::STAT_W-1:0]  status_q;

	// Cell row links: index MAX_ENTRIES is the empty slot above the top cell
	logic [idt_pkg::KEY_W-1:0] key_c [0:MAX_ENTRIES];
	logic [idt_pkg::HID_W-1:0] hid_c [0:MAX_ENTRIES];
	logic                      hit_c [0:MAX_ENTRIES];
	logic                      first_c [0:MAX_ENTRIES-1];

	logic                       in_xfer;
	logic                       commit;
	idt_pkg::op_t               op;
	logic                       any_hit;
	logic                       full;
	logic [IW-1:0]              hit_idx;
	logic [idt_pkg::HID_W-1:0]  hit_hid;
	logic                       r_hit;
	logic [IW-1:0]              r_idx;
	logic [idt_pkg::HID_W-1:0]  r_found;
	logic [CW-1:0]              r_count;
	logic [idt_pkg::STAT_W-1:0] r_status;
	logic [IW+idt_pkg::SLOT_W-1:0] slot_ext;
	logic [CW+idt_pkg::CNT_W-1:0]  cnt_ext;

	assign in_ready  = !busy_q;
	assign in_xfer   = in_valid && in_ready;
	// commit only when the result register can take the outcome
	assign commit    = busy_q && (!out_valid_q || out_ready);

	assign hit_c[0]           = 1'b0;
	assign key_c[MAX_ENTRIES] = '0;
	assign hid_c[MAX_ENTRIES] = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		idt_cell #(
			.IDX   (i),
			.CNT_W (CW)
		) u_cell (
			.clk       (clk),
			.probe_key (key_s1),
			.probe_hid (hid_s1),
			.count     (count_q),
			.op        (op),
			.prev_hit  (hit_c[i]),
			.nb_key    (key_c[i+1]),
			.nb_hid    (hid_c[i+1]),
			.key       (key_c[i]),
			.hid       (hid_c[i]),
			.first     (first_c[i]),
			.hit_out   (hit_c[i+1])
		);
	end

	assign any_hit = hit_c[MAX_ENTRIES];
	assign full    = count_q == CW'(MAX_ENTRIES);

	// At most one cell flags first match, so OR-combine its index and handler
	always_comb begin
		hit_idx = '0;
		hit_hid = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (first_c[i]) begin
				hit_idx = hit_idx | IW'(i);
				hit_hid = hit_hid | hid_c[i];
			end
		end
	end

	// Decide the outcome of the captured request
	always_comb begin
		op       = '0;
		r_hit    = 1'b0;
		r_idx    = '0;
		r_found  = '0;
		r_count  = count_q;
		r_status = idt_pkg::ST_ABSENT;
		unique case (req_s1)
			idt_pkg::REQ_STORE: begin
				if (hid_s1 != '0) begin
					priority if (any_hit) begin
						op.replace = 1'b1;
						r_hit      = 1'b1;
						r_idx      = hit_idx;
						r_status   = idt_pkg::ST_DONE;
					end else if (!full) begin
						op.append = 1'b1;
						r_idx     = IW'(count_q);
						r_count   = count_q + CW'(1);
						r_status  = idt_pkg::ST_DONE;
					end else begin
						r_status = idt_pkg::ST_FULL;
					end
				end
			end
			idt_pkg::REQ_CLEAR: begin
				if (any_hit) begin
					op.clear = 1'b1;
					r_hit    = 1'b1;
					r_idx    = hit_idx;
					r_count  = count_q - CW'(1);
					r_status = idt_pkg::ST_DONE;
				end
			end
			idt_pkg::REQ_LOOKUP: begin
				if (any_hit && (hit_hid != '0)) begin
					r_hit    = 1'b1;
					r_idx    = hit_idx;
					r_found  = hit_hid;
					r_status = idt_pkg::ST_DONE;
				end
			end
			default: begin
				// unused code: table unchanged, report absent
			end
		endcase
		// gate the table update to the commit cycle
		if (!commit) begin
			op = '0;
		end
	end

	// Mask slot and count down to their port widths
	assign slot_ext = {{idt_pkg::SLOT_W{1'b0}}, r_idx};
	assign cnt_ext  = {{idt_pkg::CNT_W{1'b0}}, r_count};

	// Hold the captured request until it commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_xfer) begin
			busy_q <= 1'b1;
		end else if (commit) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_s1 <= req_type;
			key_s1 <= source_key;
			hid_s1 <= handler_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit) begin
			count_q <= r_count;
		end
	end

	// Result register: load on commit, drop on output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q     <= r_hit;
			slot_q    <= slot_ext[idt_pkg::SLOT_W-1:0];
			found_q   <= r_found;
			cnt_out_q <= cnt_ext[idt_pkg::CNT_W-1:0];
			status_q  <= r_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign slot          = slot_q;
	assign found_handler = found_q;
	assign entry_count   = cnt_out_q;
	assign status        = status_q;

endmodule

>>> src/idt_checker.sv
`timescale 1ns / 1ps

module idt_checker #(
	parameter int MAX_ENTRIES = idt_pkg::MAX_ENTRIES_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        hit,
	input logic [idt_pkg::SLOT_W-1:0]  slot,
	input logic [idt_pkg::HID_W-1:0]   found_handler,
	input logic [idt_pkg::CNT_W-1:0]   entry_count,
	input logic [idt_pkg::STAT_W-1:0]  status
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(slot)
			&& $stable(found_handler) && $stable(entry_count) && $stable(status))
		else $error("result changed while stalled");

	// a request just taken keeps in_ready low in the next cycle
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while one is in flight");

	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> status == idt_pkg::ST_DONE)
		else $error("hit without done status");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != idt_pkg::ST_DONE |-> !hit && slot == '0
			&& found_handler == '0)
		else $error("miss result carries slot or handler");

	a_found_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found_handler != '0 |-> hit && int'(entry_count) <= MAX_ENTRIES)
		else $error("handler reported without hit");

endmodule

bind interrupt_dispatch_table idt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_idt_checker (.*);
